// ----- design/lvp_pkg.sv -----
// Package: shared types and constants for the longest valid bracket run block.
package lvp_pkg;

  localparam logic [7:0] SymOpen  = 8'd40;  // '('
  localparam logic [7:0] SymClose = 8'd41;  // ')'
  localparam int unsigned OutW    = 11;     // width of the length fields on the result

  // How the run at a closing bracket is formed
  typedef enum logic [1:0] {
    MODE_NONE,  // no run ends here
    MODE_ADJ,   // closes the bracket right before it
    MODE_FAR    // closes the bracket before the previous run
  } run_mode_e;

endpackage

// ----- design/lvp_if.sv -----
// Interfaces: valid/ready channels for string bytes and for run results.
interface lvp_in_if;
  import lvp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_string;

  modport source (output valid, output symbol, output end_of_string, input ready);
  modport sink   (input valid, input symbol, input end_of_string, output ready);
endinterface

interface lvp_out_if;
  import lvp_pkg::*;
  logic            valid;
  logic            ready;
  logic [OutW-1:0] run_here;
  logic [OutW-1:0] best_so_far;
  logic            final_res;
  logic            overflow;

  modport source (output valid, output run_here, output best_so_far, output final_res,
                  output overflow, input ready);
  modport sink   (input valid, input run_here, input best_so_far, input final_res,
                  input overflow, output ready);
endinterface

// ----- design/longest_valid_paren_run.sv -----
// Top level: longest valid bracket run over a byte stream, state held in one RAM.
//
//   channel | dir | payload                                       | handshake
//   in_i    | in  | symbol[7:0], end_of_string                    | valid/ready
//   out_o   | out | run_here[10:0], best_so_far[10:0], final_res, | valid/ready
//           |     | overflow                                      |
//
// On accept the RAM is read at the bracket that the previous run points back to;
// the compute stage then forms the run, writes the entry for this byte if it is
// stored and loads the result register. The next byte's read address depends on
// that run, so a new request is taken once the compute stage is empty.
// The result register lets one byte be taken while a result waits; a stalled
// sink holds the compute stage. Reset needs no RAM clearing pass.
module longest_valid_paren_run
  import lvp_pkg::*;
#(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lvp_in_if.sink    in_i,
  lvp_out_if.source out_o
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);  // position / run width
  localparam int unsigned AW = $clog2(MAX_LEN);      // RAM address width
  localparam int unsigned EW = PW + 1;               // entry: opener flag, run before it
  localparam logic [PW-1:0] MaxPos = PW'(MAX_LEN);
  localparam logic [PW-1:0] Two    = PW'(2);

  // entry i holds {byte i was '(', run ending at i-1}
  logic [EW-1:0] mem [MAX_LEN];
  logic [EW-1:0] rdata_q;

  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] best_q, best_d;
  logic          ovf_q, ovf_d;
  logic [PW-1:0] prev_run_q, prev_run_d;   // run ending at pos-1
  logic [PW-1:0] prev2_run_q, prev2_run_d; // run ending at pos-2
  logic          prev_open_q, prev_open_d; // byte pos-1 was '('

  logic          s1_valid_q, s1_valid_d;
  run_mode_e     s1_mode_q, s1_mode_d;
  logic          s1_open_q, s1_open_d;
  logic          s1_last_q;
  logic          s1_stored_q;

  logic            out_valid_q, out_valid_d;
  logic [OutW-1:0] out_run_q, out_best_q;
  logic            out_last_q, out_ovf_q;

  logic          accept;
  logic          done;
  logic          stored;
  logic [PW-1:0] far_k;
  logic [PW-1:0] run;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = !s1_valid_q;
  assign done      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign stored    = pos_q < MaxPos;

  // bracket index that a closing byte would pair with, past the previous run
  assign far_k = pos_q - prev_run_q - PW'(1);

  // classify the incoming byte against the state left by the previous one
  always_comb begin
    s1_open_d = (in_i.symbol == SymOpen);
    s1_mode_d = MODE_NONE;
    if (stored && in_i.symbol == SymClose && pos_q != '0) begin
      if (prev_open_q) begin
        s1_mode_d = MODE_ADJ;
      end else if (prev_run_q != '0 && prev_run_q < pos_q) begin
        s1_mode_d = MODE_FAR;
      end
    end
  end

  // RAM: read on accept, write on completion of a stored byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem[far_k[AW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= {s1_open_q, prev_run_q};
    end
  end

  assign wr_en   = done && s1_stored_q;
  assign wr_addr = pos_q[AW-1:0];

  always_comb begin
    case (s1_mode_q)
      MODE_ADJ: run = prev2_run_q + Two;
      MODE_FAR: run = rdata_q[EW-1] ? (prev_run_q + Two + rdata_q[PW-1:0]) : '0;
      default:  run = '0;
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    prev_run_d  = prev_run_q;
    prev2_run_d = prev2_run_q;
    prev_open_d = prev_open_q;
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (done) begin
      s1_valid_d  = 1'b0;
      out_valid_d = 1'b1;
      if (s1_stored_q) begin
        pos_d       = pos_q + PW'(1);
        prev2_run_d = prev_run_q;
        prev_run_d  = run;
        prev_open_d = s1_open_q;
        if (run > best_q) begin
          best_d = run;
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      prev_run_q  <= '0;
      prev2_run_q <= '0;
      prev_open_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (done && s1_last_q) begin
        // end of string: start the next one clean
        pos_q       <= '0;
        best_q      <= '0;
        ovf_q       <= 1'b0;
        prev_run_q  <= '0;
        prev2_run_q <= '0;
        prev_open_q <= 1'b0;
      end else begin
        pos_q       <= pos_d;
        best_q      <= best_d;
        ovf_q       <= ovf_d;
        prev_run_q  <= prev_run_d;
        prev2_run_q <= prev2_run_d;
        prev_open_q <= prev_open_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q   <= s1_mode_d;
      s1_open_q   <= s1_open_d;
      s1_last_q   <= in_i.end_of_string;
      s1_stored_q <= stored;
    end
    if (done) begin
      out_run_q  <= OutW'(run);
      out_best_q <= OutW'(best_d);
      out_last_q <= s1_last_q;
      out_ovf_q  <= ovf_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.run_here    = out_run_q;
  assign out_o.best_so_far = out_best_q;
  assign out_o.final_res   = out_last_q;
  assign out_o.overflow    = out_ovf_q;

endmodule
